>>> src/teq_pkg.sv
// Shared types and constants for the timed event queue.
package teq_pkg;

   // Input opcodes.
   localparam logic [1:0] OP_SCHEDULE = 2'd0;
   localparam logic [1:0] OP_TICK     = 2'd1;
   localparam logic [1:0] OP_FLUSH    = 2'd2;

   // Result kinds.
   localparam logic [2:0] KIND_DISPATCH = 3'd0;
   localparam logic [2:0] KIND_NONE_DUE = 3'd1;
   localparam logic [2:0] KIND_LATE     = 3'd2;
   localparam logic [2:0] KIND_EMPTY    = 3'd3;
   localparam logic [2:0] KIND_PAST_END = 3'd4;
   localparam logic [2:0] KIND_ACCEPTED = 3'd5;
   localparam logic [2:0] KIND_FULL     = 3'd6;

   // At most this many events leave the queue for one tick transfer.
   localparam int MAX_DISPATCH = 16;
   localparam int DISPATCH_W   = $clog2(MAX_DISPATCH);

   // Reset value of the end tick register.
   localparam logic [31:0] END_TICK_RESET = 32'hFFFF_FFFF;

   // One input item.
   typedef struct packed {
      logic [1:0]  opcode;
      logic [31:0] event_time;
      logic [31:0] instruction;
      logic [1:0]  stage;
   } req_type;

   // One result item.
   typedef struct packed {
      logic [2:0]  kind;
      logic [31:0] out_time;
      logic [31:0] out_instruction;
      logic [1:0]  out_stage;
      logic [31:0] tick_now;
      logic        last;
   } rsp_type;

   // One stored event.
   typedef struct packed {
      logic [31:0] due_time;
      logic [31:0] instruction;
      logic [1:0]  stage;
   } event_type;

   // Command broadcast to every cell of the chain.
   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_POP
   } cell_cmd_type;

   // Controller states.
   typedef enum logic {
      ST_IDLE,
      ST_TICK
   } state_type;

endpackage

>>> src/teq_cell.sv
// One slot of the sorted event chain: holds an event and trades it with its neighbors.
module teq_cell (
   input  logic                  clock,
   input  teq_pkg::cell_cmd_type cmd,
   input  teq_pkg::event_type    new_event,
   input  teq_pkg::event_type    left_event,
   input  teq_pkg::event_type    right_event,
   input  logic                  left_gt,
   input  logic                  occupied,
   output teq_pkg::event_type    slot,
   output logic                  gt
);

   teq_pkg::event_type slot_ff;
   teq_pkg::event_type slot_in;

   // This slot lies at or past the insert point when it is empty or due later.
   assign gt = !occupied || (slot_ff.due_time > new_event.due_time);

   // On insert, slots past the insert point shift right; the first of them takes the
   // new event. On pop, every slot takes its right neighbor; the tail keeps its own.
   always_comb begin
      slot_in = slot_ff;
      case (cmd)
         teq_pkg::CELL_INSERT: begin
            if (gt) begin
               slot_in = left_gt ? left_event : new_event;
            end
         end
         teq_pkg::CELL_POP: begin
            slot_in = right_event;
         end
         default: begin
            slot_in = slot_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
   end

   assign slot = slot_ff;

endmodule

>>> src/timed_event_queue.sv
// Top level of the timed event queue: controller, tick counter and the chain of slots.
//
// Events are kept sorted by due tick in a chain of QUEUE_DEPTH slot cells, head first;
// events due at the same tick stay in arrival order. When a schedule transfer is taken,
// every cell compares its due tick with the new one in parallel and, unless the queue
// is full, the chain shifts right by one at the insert point; the accepted or full result
// is loaded into the output register in that same cycle. A tick transfer moves the
// controller to the tick state, which then gives its results one after another, from 1
// to 16 of them, each dispatch result leaving the head of the chain as the chain shifts
// left by one. A new transfer is taken only when the controller is idle and the output
// register is free or being emptied in that cycle; a result that waits for rsp_ready
// stalls the controller. A flush transfer empties the queue and gives no result. The end
// tick register may be written at any cycle while the block is idle; csr_ready is always
// high.
module timed_event_queue #(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  teq_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output teq_pkg::rsp_type rsp_payload,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [31:0]      csr_data
);

   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   teq_pkg::state_type          state_ff, state_in;
   logic [teq_pkg::DISPATCH_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0]            occupancy_ff, occupancy_in;
   logic [31:0]                 tick_ff, tick_in;
   logic [31:0]                 end_tick_ff, end_tick_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   teq_pkg::rsp_type            rsp_payload_ff, rsp_payload_in;
   teq_pkg::cell_cmd_type       cell_cmd;

   teq_pkg::event_type          new_event;
   teq_pkg::event_type          slot [QUEUE_DEPTH];
   logic [QUEUE_DEPTH-1:0]      gt;
   logic [QUEUE_DEPTH-1:0]      occupied;

   logic                        out_free;
   logic                        req_fire;
   logic                        next_due;

   // The event offered by the current input transfer.
   assign new_event.due_time    = req_payload.event_time;
   assign new_event.instruction = req_payload.instruction;
   assign new_event.stage       = req_payload.stage;

   // Chain of slot cells; slot 0 is the head.
   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      assign occupied[i] = (CNT_W'(i) < occupancy_ff);

      if (i == 0) begin : g_head
         teq_cell u_cell (
            .clock       (clock),
            .cmd         (cell_cmd),
            .new_event   (new_event),
            .left_event  (new_event),
            .right_event (slot[1]),
            .left_gt     (1'b0),
            .occupied    (occupied[0]),
            .slot        (slot[0]),
            .gt          (gt[0])
         );
      end else if (i == QUEUE_DEPTH - 1) begin : g_tail
         teq_cell u_cell (
            .clock       (clock),
            .cmd         (cell_cmd),
            .new_event   (new_event),
            .left_event  (slot[i-1]),
            .right_event (slot[i]),
            .left_gt     (gt[i-1]),
            .occupied    (occupied[i]),
            .slot        (slot[i]),
            .gt          (gt[i])
         );
      end else begin : g_mid
         teq_cell u_cell (
            .clock       (clock),
            .cmd         (cell_cmd),
            .new_event   (new_event),
            .left_event  (slot[i-1]),
            .right_event (slot[i+1]),
            .left_gt     (gt[i-1]),
            .occupied    (occupied[i]),
            .slot        (slot[i]),
            .gt          (gt[i])
         );
      end
   end

   // Handshakes.
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == teq_pkg::ST_IDLE) && out_free;
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;

   // The event behind the head is also due at the current tick.
   assign next_due = (occupancy_ff > CNT_W'(1)) && (slot[1].due_time == tick_ff);

   // Configuration register write.
   assign end_tick_in = (csr_valid && csr_ready) ? csr_data : end_tick_ff;

   // Next state, chain command and result loading.
   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      occupancy_in   = occupancy_ff;
      tick_in        = tick_ff;
      cell_cmd       = teq_pkg::CELL_HOLD;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_payload_in = rsp_payload_ff;

      case (state_ff)
         teq_pkg::ST_IDLE: begin
            if (req_fire) begin
               case (req_payload.opcode)
                  teq_pkg::OP_SCHEDULE: begin
                     rsp_valid_in            = 1'b1;
                     rsp_payload_in          = '0;
                     rsp_payload_in.tick_now = tick_ff;
                     rsp_payload_in.last     = 1'b1;
                     if (occupancy_ff >= CNT_W'(QUEUE_DEPTH)) begin
                        rsp_payload_in.kind = teq_pkg::KIND_FULL;
                     end else begin
                        rsp_payload_in.kind = teq_pkg::KIND_ACCEPTED;
                        cell_cmd            = teq_pkg::CELL_INSERT;
                        occupancy_in        = occupancy_ff + CNT_W'(1);
                     end
                  end
                  teq_pkg::OP_TICK: begin
                     state_in = teq_pkg::ST_TICK;
                     count_in = '0;
                  end
                  teq_pkg::OP_FLUSH: begin
                     occupancy_in = '0;
                  end
                  default: begin
                     state_in = teq_pkg::ST_IDLE;
                  end
               endcase
            end
         end

         teq_pkg::ST_TICK: begin
            if (out_free) begin
               rsp_valid_in            = 1'b1;
               rsp_payload_in          = '0;
               rsp_payload_in.tick_now = tick_ff;
               rsp_payload_in.last     = 1'b1;
               if ((count_ff == '0) && (tick_ff > end_tick_ff)) begin
                  rsp_payload_in.kind = teq_pkg::KIND_PAST_END;
                  state_in            = teq_pkg::ST_IDLE;
               end else if ((count_ff == '0) && (occupancy_ff == '0)) begin
                  rsp_payload_in.kind = teq_pkg::KIND_EMPTY;
                  state_in            = teq_pkg::ST_IDLE;
               end else if ((count_ff == '0) && (slot[0].due_time < tick_ff)) begin
                  rsp_payload_in.kind = teq_pkg::KIND_LATE;
                  state_in            = teq_pkg::ST_IDLE;
               end else if ((count_ff == '0) && (slot[0].due_time != tick_ff)) begin
                  rsp_payload_in.kind = teq_pkg::KIND_NONE_DUE;
                  state_in            = teq_pkg::ST_IDLE;
                  tick_in             = tick_ff + 32'd1;
               end else begin
                  // The head is due: hand it out and shift the chain left.
                  rsp_payload_in.kind            = teq_pkg::KIND_DISPATCH;
                  rsp_payload_in.out_time        = slot[0].due_time;
                  rsp_payload_in.out_instruction = slot[0].instruction;
                  rsp_payload_in.out_stage       = slot[0].stage;
                  rsp_payload_in.last            = !next_due ||
                     (count_ff == teq_pkg::DISPATCH_W'(teq_pkg::MAX_DISPATCH - 1));
                  cell_cmd     = teq_pkg::CELL_POP;
                  occupancy_in = occupancy_ff - CNT_W'(1);
                  if (rsp_payload_in.last) begin
                     state_in = teq_pkg::ST_IDLE;
                     if (!next_due) begin
                        tick_in = tick_ff + 32'd1;
                     end
                  end else begin
                     count_in = count_ff + teq_pkg::DISPATCH_W'(1);
                  end
               end
            end
         end

         default: begin
            state_in = teq_pkg::ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= teq_pkg::ST_IDLE;
         count_ff     <= '0;
         occupancy_ff <= '0;
         tick_ff      <= '0;
         end_tick_ff  <= teq_pkg::END_TICK_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         occupancy_ff <= occupancy_in;
         tick_ff      <= tick_in;
         end_tick_ff  <= end_tick_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Output payload register.
   always_ff @(posedge clock) begin
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule
